/* rtl/core/kwm_pkg.sv */
package kwm_pkg;

  localparam int NUM_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 8;
  localparam int LIST_NUM_W     = 3;
  localparam int VALUE_W        = 32;

  typedef struct packed {
    logic [LIST_NUM_W-1:0]     list_number;
    logic signed [VALUE_W-1:0] element_value;
    logic                      end_of_load;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] merged_value;
    logic                      final_result;
    logic                      dropped_flag;
  } out_word_t;

  // queued word: input word plus the front's range check
  typedef struct packed {
    logic [LIST_NUM_W-1:0]     list_number;
    logic signed [VALUE_W-1:0] element_value;
    logic                      end_of_load;
    logic                      in_range;
  } q_word_t;

endpackage

/* rtl/core/kwm_front.sv */
module kwm_front #(
  parameter int NUM_LISTS = kwm_pkg::NUM_LISTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kwm_pkg::in_word_t in_data,
  output logic              q_valid,
  output kwm_pkg::q_word_t  q_word,
  input  logic              q_pop
);

  localparam int QDEPTH = 2;

  kwm_pkg::q_word_t slot_r [QDEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  kwm_pkg::q_word_t push_word;

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = slot_r[rd_ptr_r];

  always_comb begin
    push_word.list_number   = in_data.list_number;
    push_word.element_value = in_data.element_value;
    push_word.end_of_load   = in_data.end_of_load;
    push_word.in_range      = (32'(in_data.list_number) < 32'(NUM_LISTS));
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* rtl/core/kwm_tree.sv */
module kwm_tree #(
  parameter int NUM_LISTS = kwm_pkg::NUM_LISTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [NUM_LISTS-1:0]                 leaf_vld,
  input  logic signed [kwm_pkg::VALUE_W-1:0]   leaf_val [NUM_LISTS],
  output logic                                 root_vld,
  output logic signed [kwm_pkg::VALUE_W-1:0]   root_val,
  output logic [$clog2(NUM_LISTS)-1:0]         root_lane
);

  localparam int LW = $clog2(NUM_LISTS);
  localparam int P  = 1 << LW;

  // node i has children 2i and 2i+1; leaves sit at P..2P-1
  logic                               t_vld [1:2*P-1];
  logic signed [kwm_pkg::VALUE_W-1:0] t_val [1:2*P-1];
  logic [LW-1:0]                      t_idx [1:2*P-1];
  logic                               take_right [1:P-1];

  logic                               nd_vld_r [1:P-1];
  logic signed [kwm_pkg::VALUE_W-1:0] nd_val_r [1:P-1];
  logic [LW-1:0]                      nd_idx_r [1:P-1];

  always_comb begin
    for (int k = 0; k < NUM_LISTS; k++) begin
      t_vld[P+k] = leaf_vld[k];
      t_val[P+k] = leaf_val[k];
      t_idx[P+k] = LW'(k);
    end
    for (int k = NUM_LISTS; k < P; k++) begin
      t_vld[P+k] = 1'b0;
      t_val[P+k] = '0;
      t_idx[P+k] = LW'(k);
    end
    for (int k = 1; k < P; k++) begin
      t_vld[k] = nd_vld_r[k];
      t_val[k] = nd_val_r[k];
      t_idx[k] = nd_idx_r[k];
    end
  end

  // ties go left: the left subtree holds the lower list numbers
  always_comb begin
    for (int k = 1; k < P; k++) begin
      take_right[k] = t_vld[2*k+1] &&
                      (!t_vld[2*k] || (t_val[2*k+1] < t_val[2*k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k < P; k++) begin
        nd_vld_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 1; k < P; k++) begin
        nd_vld_r[k] <= take_right[k] ? t_vld[2*k+1] : t_vld[2*k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k < P; k++) begin
      nd_val_r[k] <= take_right[k] ? t_val[2*k+1] : t_val[2*k];
      nd_idx_r[k] <= take_right[k] ? t_idx[2*k+1] : t_idx[2*k];
    end
  end

  assign root_vld  = t_vld[1];
  assign root_val  = t_val[1];
  assign root_lane = t_idx[1];

endmodule

/* rtl/core/kwm_back.sv */
module kwm_back #(
  parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  kwm_pkg::q_word_t   q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output kwm_pkg::out_word_t out_data
);

  localparam int LW        = $clog2(NUM_LISTS);
  localparam int CW        = $clog2(LIST_DEPTH + 1);
  localparam int PW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int AW        = LW + PW;
  localparam int MEM_DEPTH = NUM_LISTS * (1 << PW);
  localparam int RW        = $clog2(NUM_LISTS * LIST_DEPTH + 1);
  localparam int WCW       = $clog2(LW + 1);

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_INIT_RD = 7'b0000010,
    S_INIT_WR = 7'b0000100,
    S_WAIT    = 7'b0001000,
    S_SEL     = 7'b0010000,
    S_REFILL  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [LW-1:0]                      ini_cnt_r, ini_cnt_nxt;
  logic [WCW-1:0]                     wait_cnt_r, wait_cnt_nxt;
  logic [RW-1:0]                      remain_r, remain_nxt;
  logic                               ovf_r, ovf_nxt;
  logic [LW-1:0]                      ref_lane_r, ref_lane_nxt;
  logic                               ref_more_r, ref_more_nxt;
  logic                               out_vld_r, out_vld_nxt;
  kwm_pkg::out_word_t                 out_data_r, out_data_nxt;

  logic [CW-1:0]                      len_r [NUM_LISTS];
  logic [CW-1:0]                      pos_r [NUM_LISTS];
  logic [NUM_LISTS-1:0]               leaf_vld_r;
  logic signed [kwm_pkg::VALUE_W-1:0] leaf_val_r [NUM_LISTS];

  logic signed [kwm_pkg::VALUE_W-1:0] store_r [MEM_DEPTH];
  logic signed [kwm_pkg::VALUE_W-1:0] rd_data_r;
  logic [AW-1:0]                      rd_addr;
  logic [AW-1:0]                      wr_addr;

  logic [LW+kwm_pkg::LIST_NUM_W-1:0]  ld_ext;
  logic [LW-1:0]                      ld_lane;
  logic                               ld_ok;
  logic [NUM_LISTS-1:0]               full;
  logic [NUM_LISTS-1:0]               more;
  logic                               mem_we, init_we, refill_we, clear;

  logic                               root_vld;
  logic signed [kwm_pkg::VALUE_W-1:0] root_val;
  logic [LW-1:0]                      root_lane;
  logic [CW-1:0]                      pos_sel;

  kwm_tree #(
    .NUM_LISTS (NUM_LISTS)
  ) u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .leaf_vld  (leaf_vld_r),
    .leaf_val  (leaf_val_r),
    .root_vld  (root_vld),
    .root_val  (root_val),
    .root_lane (root_lane)
  );

  always_comb begin
    for (int j = 0; j < NUM_LISTS; j++) begin
      full[j] = (len_r[j] == CW'(LIST_DEPTH));
      more[j] = (pos_r[j] < len_r[j]);
    end
  end

  assign ld_ext  = {{LW{1'b0}}, q_word.list_number};
  assign ld_lane = ld_ext[LW-1:0];
  assign ld_ok   = q_word.in_range && !full[ld_lane];
  assign wr_addr = {ld_lane, len_r[ld_lane][PW-1:0]};
  assign pos_sel = pos_r[root_lane];
  assign rd_addr = (state_r == S_INIT_RD) ? {ini_cnt_r, PW'(0)}
                                          : {root_lane, pos_sel[PW-1:0]};

  always_comb begin
    state_nxt    = state_r;
    ini_cnt_nxt  = ini_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    remain_nxt   = remain_r;
    ovf_nxt      = ovf_r;
    ref_lane_nxt = ref_lane_r;
    ref_more_nxt = ref_more_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    init_we      = 1'b0;
    refill_we    = 1'b0;
    clear        = 1'b0;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (ld_ok) begin
            mem_we     = 1'b1;
            remain_nxt = remain_r + RW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_word.end_of_load) begin
            ini_cnt_nxt = '0;
            state_nxt   = (remain_nxt == '0) ? S_DONE : S_INIT_RD;
          end
        end
      end
      S_INIT_RD: begin
        state_nxt = S_INIT_WR;
      end
      S_INIT_WR: begin
        init_we = 1'b1;
        if (ini_cnt_r == LW'(NUM_LISTS - 1)) begin
          wait_cnt_nxt = WCW'(LW - 1);
          state_nxt    = S_WAIT;
        end else begin
          ini_cnt_nxt = ini_cnt_r + LW'(1);
          state_nxt   = S_INIT_RD;
        end
      end
      S_WAIT: begin
        // let the registered levels of the tree settle
        if (wait_cnt_r == '0) begin
          state_nxt = S_SEL;
        end else begin
          wait_cnt_nxt = wait_cnt_r - WCW'(1);
        end
      end
      S_SEL: begin
        if (root_vld && (!out_vld_r || out_ready)) begin
          out_vld_nxt               = 1'b1;
          out_data_nxt.merged_value = root_val;
          out_data_nxt.final_result = (remain_r == RW'(1));
          out_data_nxt.dropped_flag = ovf_r;
          ref_lane_nxt              = root_lane;
          ref_more_nxt              = more[root_lane];
          remain_nxt                = remain_r - RW'(1);
          state_nxt                 = (remain_r == RW'(1)) ? S_DONE : S_REFILL;
        end
      end
      S_REFILL: begin
        refill_we    = 1'b1;
        wait_cnt_nxt = WCW'(LW - 1);
        state_nxt    = S_WAIT;
      end
      S_DONE: begin
        clear     = 1'b1;
        ovf_nxt   = 1'b0;
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      ini_cnt_r  <= '0;
      wait_cnt_r <= '0;
      remain_r   <= '0;
      ovf_r      <= 1'b0;
      ref_lane_r <= '0;
      ref_more_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ini_cnt_r  <= ini_cnt_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      remain_r   <= remain_nxt;
      ovf_r      <= ovf_nxt;
      ref_lane_r <= ref_lane_nxt;
      ref_more_r <= ref_more_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // per-list counts and heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_LISTS; j++) begin
        len_r[j] <= '0;
        pos_r[j] <= '0;
      end
      leaf_vld_r <= '0;
    end else begin
      for (int j = 0; j < NUM_LISTS; j++) begin
        if (clear) begin
          len_r[j]      <= '0;
          pos_r[j]      <= '0;
          leaf_vld_r[j] <= 1'b0;
        end else begin
          if (mem_we && ld_lane == LW'(j)) begin
            len_r[j] <= len_r[j] + CW'(1);
          end
          if (init_we && ini_cnt_r == LW'(j)) begin
            leaf_vld_r[j] <= (len_r[j] != '0);
            pos_r[j]      <= CW'(1);
          end
          if (refill_we && ref_lane_r == LW'(j)) begin
            if (ref_more_r) begin
              pos_r[j] <= pos_r[j] + CW'(1);
            end else begin
              leaf_vld_r[j] <= 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_LISTS; j++) begin
      if ((init_we && ini_cnt_r == LW'(j)) ||
          (refill_we && ref_more_r && ref_lane_r == LW'(j))) begin
        leaf_val_r[j] <= rd_data_r;
      end
    end
  end

  // element store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[wr_addr] <= q_word.element_value;
    end
    rd_data_r <= store_r[rd_addr];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/k_way_sorted_list_merge_top.sv */
// K-way sorted list merge.
// Input words carry a list number, a signed value and an end-of-load bit;
// each value is appended to its list (up to LIST_DEPTH per list, up to
// NUM_LISTS lists). A value for a full list or a list number out of range
// is dropped and remembered. The word with end_of_load set closes the set.
// The block then emits every stored value in ascending order (ties by list
// number, then load order), final_result marking the last word and
// dropped_flag on every word if anything was dropped. An empty set gives
// no output. Lists are then cleared for the next set.
// Loading: one word per cycle through a 2-word queue. Merge start-up:
// the list heads are read one list at a time into the tree leaves, then
// the tournament tree settles. Each output word then takes one store read
// and a refill, and the next word is chosen only once the registered tree
// levels have settled. in_ready falls once the queue fills during a merge.
// Synchronous reset clears the lists, queue and output valid flag. A stalled
// out_ready holds the output word and pauses the merge.
module k_way_sorted_list_merge_top #(
  parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kwm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kwm_pkg::out_word_t out_data
);

  logic             q_valid;
  logic             q_pop;
  kwm_pkg::q_word_t q_word;

  kwm_front #(
    .NUM_LISTS (NUM_LISTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  kwm_back #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
